[sv/lsa_pkg.sv]
// types and constants for the lddt score accumulator
// no dependencies; used by lddt_score_accumulator_unit
`default_nettype none

package lsa_pkg;

    // field and register widths
    localparam int unsigned DIST_W     = 16;
    localparam int unsigned CNT_W      = 13;
    localparam int unsigned ROWS_W     = 11;
    localparam int unsigned PTOT_W     = 27;
    localparam int unsigned STOT_W     = 32;
    localparam int unsigned PAIRS_W    = 16;
    localparam int unsigned SCORE_W    = 17;
    localparam int unsigned TCNT_W     = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // thresholds held in the block
    localparam int unsigned THR_NUM   = 4;
    localparam int unsigned THR_IDX_W = 2;

    // shared divider: 32-bit dividend, 16-bit divisor, one quotient bit a cycle
    localparam int unsigned DIV_W     = 32;
    localparam int unsigned DEN_W     = 16;
    localparam int unsigned DIV_CNT_W = 6;

    localparam logic [SCORE_W-1:0] ONE_Q16 = 17'h10000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_ONLY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_C = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_D = 3'd6;

    // register reset values
    localparam logic [DIST_W-1:0] RADIUS_RST    = 16'd3840;
    localparam logic [TCNT_W-1:0] THR_COUNT_RST = 3'd4;
    localparam logic [DIST_W-1:0] THR_A_RST     = 16'd128;
    localparam logic [DIST_W-1:0] THR_B_RST     = 16'd256;
    localparam logic [DIST_W-1:0] THR_C_RST     = 16'd512;
    localparam logic [DIST_W-1:0] THR_D_RST     = 16'd1024;

    // result kinds
    localparam logic KIND_PAIR = 1'b0;
    localparam logic KIND_SET  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_ROW_CLOSE,
        ST_DIV_ROW,
        ST_PAIR_CHECK,
        ST_DIV_PAIR,
        ST_PUT_PAIR,
        ST_DIV_SET,
        ST_PUT_SET
    } t_state;

endpackage

`default_nettype wire

[sv/lddt_score_accumulator_unit.sv]
// lddt score accumulator: top level, sequencer, one compare unit, one divider
// depends on lsa_pkg
// sequence: an item is taken in idle, then compared against each threshold in use (1 to 4)
//   in turn when it is counted, then the row close is decided
// a row close goes on to a check for a pair close, with a division in the shared
//   restoring divider (32 quotient bits and a finish step) first when the row is usable
// a pair close adds a division and the loading of the pair word, a set close another
//   division and the loading of the overall word; output stalls lengthen this
// throughput: one item at a time, taken again only once the sequencer is back in idle
// reset: synchronous, active low; registers to their reset values, all totals cleared
`default_nettype none

module lddt_score_accumulator_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration write channel
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [lsa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [lsa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input item channel
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  [lsa_pkg::DIST_W-1:0]       i_dist_one,
    input  wire  [lsa_pkg::DIST_W-1:0]       i_dist_two,
    input  wire                              i_row_core,
    input  wire                              i_partner_core,
    input  wire                              i_row_aligned,
    input  wire                              i_partner_aligned,
    input  wire                              i_same_column,
    input  wire                              i_row_end,
    input  wire                              i_pair_end,
    input  wire                              i_set_end,
    // result channel
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic                             o_kind,
    output logic [lsa_pkg::SCORE_W-1:0]      o_score,
    output logic                             o_last
);

    // sequencer state
    lsa_pkg::t_state r_state, n_state;

    // configuration registers
    logic                          r_core_only, n_core_only;
    logic [lsa_pkg::DIST_W-1:0]    r_radius, n_radius;
    logic [lsa_pkg::TCNT_W-1:0]    r_thr_count, n_thr_count;
    logic [lsa_pkg::DIST_W-1:0]    r_thr [lsa_pkg::THR_NUM];
    logic [lsa_pkg::DIST_W-1:0]    n_thr [lsa_pkg::THR_NUM];

    // the item at work
    logic [lsa_pkg::DIST_W-1:0]    r_diff, n_diff;
    logic [lsa_pkg::THR_IDX_W-1:0] r_k, n_k;
    logic [lsa_pkg::THR_IDX_W-1:0] r_klast, n_klast;
    logic                          r_row_ok, n_row_ok;
    logic                          r_row_close, n_row_close;
    logic                          r_pair_close, n_pair_close;
    logic                          r_set_close, n_set_close;

    // running counts and totals
    logic [lsa_pkg::CNT_W-1:0]     r_row_cons, n_row_cons;
    logic [lsa_pkg::CNT_W-1:0]     r_row_pres, n_row_pres;
    logic [lsa_pkg::PTOT_W-1:0]    r_pair_total, n_pair_total;
    logic [lsa_pkg::ROWS_W-1:0]    r_pair_rows, n_pair_rows;
    logic [lsa_pkg::STOT_W-1:0]    r_set_total, n_set_total;
    logic [lsa_pkg::PAIRS_W-1:0]   r_set_pairs, n_set_pairs;

    // shared divider: r_num shifts the dividend out and the quotient in
    logic [lsa_pkg::DIV_W-1:0]     r_num, n_num;
    logic [lsa_pkg::DEN_W-1:0]     r_den, n_den;
    logic [lsa_pkg::DEN_W-1:0]     r_rem, n_rem;
    logic [lsa_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic [lsa_pkg::SCORE_W-1:0]   r_quot, n_quot;

    // output register
    logic                          r_out_valid, n_out_valid;
    logic                          r_out_kind, n_out_kind;
    logic [lsa_pkg::SCORE_W-1:0]   r_out_score, n_out_score;
    logic                          r_out_last, n_out_last;

    // combinational helpers
    logic                          in_take;
    logic                          in_row_ok;
    logic                          in_counted;
    logic [lsa_pkg::DIST_W-1:0]    in_diff;
    logic [lsa_pkg::THR_IDX_W-1:0] in_klast;
    logic                          out_free;
    logic                          div_done;
    logic [lsa_pkg::DEN_W:0]       div_shift;
    logic [lsa_pkg::DEN_W:0]       div_sub;
    logic                          div_ge;
    logic [lsa_pkg::SCORE_W-1:0]   div_q;
    logic                          cmp_hit;
    logic [lsa_pkg::CNT_W-1:0]     row_cons_inc;
    logic [lsa_pkg::CNT_W-1:0]     row_pres_inc;
    logic [lsa_pkg::PTOT_W:0]      pair_sum;
    logic [lsa_pkg::ROWS_W-1:0]    pair_rows_inc;
    logic [lsa_pkg::STOT_W:0]      set_sum;
    logic [lsa_pkg::PAIRS_W-1:0]   set_pairs_inc;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == lsa_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_score     = r_out_score;
    assign o_last      = r_out_last;

    assign in_take  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign div_done = r_div_cnt[lsa_pkg::DIV_CNT_W-1];

    // row usable and partner counted, judged with the registers as they stand
    assign in_row_ok  = i_row_aligned && (!r_core_only || i_row_core);
    assign in_counted = in_row_ok && !i_same_column && i_partner_aligned
                        && (!r_core_only || i_partner_core) && (i_dist_one <= r_radius);
    assign in_diff    = (i_dist_one >= i_dist_two) ? (i_dist_one - i_dist_two)
                                                   : (i_dist_two - i_dist_one);

    // index of the last threshold in use: zero acts as one, above four saturates
    always_comb begin
        if (r_thr_count == '0) begin
            in_klast = '0;
        end else if (r_thr_count >= lsa_pkg::TCNT_W'(lsa_pkg::THR_NUM)) begin
            in_klast = lsa_pkg::THR_IDX_W'(lsa_pkg::THR_NUM - 1);
        end else begin
            in_klast = r_thr_count[lsa_pkg::THR_IDX_W-1:0] - 1'b1;
        end
    end

    // one threshold compare per cycle
    assign cmp_hit = (r_diff <= r_thr[r_k]);

    // one restoring division step per cycle
    assign div_shift = {r_rem, r_num[lsa_pkg::DIV_W-1]};
    assign div_ge    = (div_shift >= {1'b0, r_den});
    assign div_sub   = div_shift - {1'b0, r_den};

    // finished quotient: zero divisor gives zero, clamped to one
    always_comb begin
        if (r_den == '0) begin
            div_q = '0;
        end else if (r_num > lsa_pkg::DIV_W'(lsa_pkg::ONE_Q16)) begin
            div_q = lsa_pkg::ONE_Q16;
        end else begin
            div_q = r_num[lsa_pkg::SCORE_W-1:0];
        end
    end

    // saturating counters and totals
    assign row_cons_inc  = (&r_row_cons) ? r_row_cons : r_row_cons + 1'b1;
    assign row_pres_inc  = (&r_row_pres) ? r_row_pres : r_row_pres + 1'b1;
    assign pair_sum      = {1'b0, r_pair_total} + (lsa_pkg::PTOT_W + 1)'(div_q);
    assign pair_rows_inc = (&r_pair_rows) ? r_pair_rows : r_pair_rows + 1'b1;
    assign set_sum       = {1'b0, r_set_total} + (lsa_pkg::STOT_W + 1)'(div_q);
    assign set_pairs_inc = (&r_set_pairs) ? r_set_pairs : r_set_pairs + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsa_pkg::ST_IDLE: begin
                if (in_take) begin
                    n_state = in_counted ? lsa_pkg::ST_COMPARE : lsa_pkg::ST_ROW_CLOSE;
                end
            end
            lsa_pkg::ST_COMPARE: begin
                if (r_k == r_klast) begin
                    n_state = lsa_pkg::ST_ROW_CLOSE;
                end
            end
            lsa_pkg::ST_ROW_CLOSE: begin
                if (!r_row_close) begin
                    n_state = lsa_pkg::ST_IDLE;
                end else if (r_row_ok) begin
                    n_state = lsa_pkg::ST_DIV_ROW;
                end else begin
                    n_state = lsa_pkg::ST_PAIR_CHECK;
                end
            end
            lsa_pkg::ST_DIV_ROW: begin
                if (div_done) begin
                    n_state = lsa_pkg::ST_PAIR_CHECK;
                end
            end
            lsa_pkg::ST_PAIR_CHECK: begin
                n_state = r_pair_close ? lsa_pkg::ST_DIV_PAIR : lsa_pkg::ST_IDLE;
            end
            lsa_pkg::ST_DIV_PAIR: begin
                if (div_done) begin
                    n_state = lsa_pkg::ST_PUT_PAIR;
                end
            end
            lsa_pkg::ST_PUT_PAIR: begin
                if (out_free) begin
                    n_state = r_set_close ? lsa_pkg::ST_DIV_SET : lsa_pkg::ST_IDLE;
                end
            end
            lsa_pkg::ST_DIV_SET: begin
                if (div_done) begin
                    n_state = lsa_pkg::ST_PUT_SET;
                end
            end
            lsa_pkg::ST_PUT_SET: begin
                if (out_free) begin
                    n_state = lsa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lsa_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_core_only  = r_core_only;
        n_radius     = r_radius;
        n_thr_count  = r_thr_count;
        n_thr        = r_thr;
        n_diff       = r_diff;
        n_k          = r_k;
        n_klast      = r_klast;
        n_row_ok     = r_row_ok;
        n_row_close  = r_row_close;
        n_pair_close = r_pair_close;
        n_set_close  = r_set_close;
        n_row_cons   = r_row_cons;
        n_row_pres   = r_row_pres;
        n_pair_total = r_pair_total;
        n_pair_rows  = r_pair_rows;
        n_set_total  = r_set_total;
        n_set_pairs  = r_set_pairs;
        n_num        = r_num;
        n_den        = r_den;
        n_rem        = r_rem;
        n_div_cnt    = r_div_cnt;
        n_quot       = r_quot;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_kind   = r_out_kind;
        n_out_score  = r_out_score;
        n_out_last   = r_out_last;

        // register writes, accepted on every cycle
        if (i_cfg_valid) begin
            case (i_cfg_index)
                lsa_pkg::CFG_CORE_ONLY:   n_core_only = i_cfg_data[0];
                lsa_pkg::CFG_RADIUS:      n_radius    = i_cfg_data;
                lsa_pkg::CFG_THR_COUNT:   n_thr_count = i_cfg_data[lsa_pkg::TCNT_W-1:0];
                lsa_pkg::CFG_THRESHOLD_A: n_thr[0]    = i_cfg_data;
                lsa_pkg::CFG_THRESHOLD_B: n_thr[1]    = i_cfg_data;
                lsa_pkg::CFG_THRESHOLD_C: n_thr[2]    = i_cfg_data;
                lsa_pkg::CFG_THRESHOLD_D: n_thr[3]    = i_cfg_data;
                default: ;
            endcase
        end

        // divider step in any division state until 32 bits are out
        if ((r_state == lsa_pkg::ST_DIV_ROW || r_state == lsa_pkg::ST_DIV_PAIR
             || r_state == lsa_pkg::ST_DIV_SET) && !div_done) begin
            n_rem     = div_ge ? div_sub[lsa_pkg::DEN_W-1:0] : div_shift[lsa_pkg::DEN_W-1:0];
            n_num     = {r_num[lsa_pkg::DIV_W-2:0], div_ge};
            n_div_cnt = r_div_cnt + 1'b1;
        end

        case (r_state)
            lsa_pkg::ST_IDLE: begin
                if (in_take) begin
                    n_diff       = in_diff;
                    n_k          = '0;
                    n_klast      = in_klast;
                    n_row_ok     = in_row_ok;
                    n_row_close  = i_row_end || i_pair_end || i_set_end;
                    n_pair_close = i_pair_end || i_set_end;
                    n_set_close  = i_set_end;
                end
            end
            lsa_pkg::ST_COMPARE: begin
                n_row_cons = row_cons_inc;
                if (cmp_hit) begin
                    n_row_pres = row_pres_inc;
                end
                n_k = r_k + 1'b1;
            end
            lsa_pkg::ST_ROW_CLOSE: begin
                if (r_row_close) begin
                    if (r_row_ok) begin
                        // row score: preserved << 16 over considered
                        n_num     = {3'b000, r_row_pres, 16'h0000};
                        n_den     = lsa_pkg::DEN_W'(r_row_cons);
                        n_rem     = '0;
                        n_div_cnt = '0;
                    end else begin
                        n_row_cons = '0;
                        n_row_pres = '0;
                    end
                end
            end
            lsa_pkg::ST_DIV_ROW: begin
                if (div_done) begin
                    n_pair_total = pair_sum[lsa_pkg::PTOT_W] ? '1
                                                             : pair_sum[lsa_pkg::PTOT_W-1:0];
                    n_pair_rows  = pair_rows_inc;
                    n_row_cons   = '0;
                    n_row_pres   = '0;
                end
            end
            lsa_pkg::ST_PAIR_CHECK: begin
                if (r_pair_close) begin
                    n_num     = lsa_pkg::DIV_W'(r_pair_total);
                    n_den     = lsa_pkg::DEN_W'(r_pair_rows);
                    n_rem     = '0;
                    n_div_cnt = '0;
                end
            end
            lsa_pkg::ST_DIV_PAIR: begin
                if (div_done) begin
                    n_quot       = div_q;
                    n_set_total  = set_sum[lsa_pkg::STOT_W] ? '1
                                                            : set_sum[lsa_pkg::STOT_W-1:0];
                    n_set_pairs  = set_pairs_inc;
                    n_pair_total = '0;
                    n_pair_rows  = '0;
                end
            end
            lsa_pkg::ST_PUT_PAIR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = lsa_pkg::KIND_PAIR;
                    n_out_score = r_quot;
                    n_out_last  = !r_set_close;
                    if (r_set_close) begin
                        n_num     = r_set_total;
                        n_den     = r_set_pairs;
                        n_rem     = '0;
                        n_div_cnt = '0;
                    end
                end
            end
            lsa_pkg::ST_DIV_SET: begin
                if (div_done) begin
                    n_quot      = div_q;
                    n_set_total = '0;
                    n_set_pairs = '0;
                end
            end
            lsa_pkg::ST_PUT_SET: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = lsa_pkg::KIND_SET;
                    n_out_score = r_quot;
                    n_out_last  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control state, registers and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lsa_pkg::ST_IDLE;
            r_core_only  <= 1'b0;
            r_radius     <= lsa_pkg::RADIUS_RST;
            r_thr_count  <= lsa_pkg::THR_COUNT_RST;
            r_thr[0]     <= lsa_pkg::THR_A_RST;
            r_thr[1]     <= lsa_pkg::THR_B_RST;
            r_thr[2]     <= lsa_pkg::THR_C_RST;
            r_thr[3]     <= lsa_pkg::THR_D_RST;
            r_row_cons   <= '0;
            r_row_pres   <= '0;
            r_pair_total <= '0;
            r_pair_rows  <= '0;
            r_set_total  <= '0;
            r_set_pairs  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_core_only  <= n_core_only;
            r_radius     <= n_radius;
            r_thr_count  <= n_thr_count;
            r_thr        <= n_thr;
            r_row_cons   <= n_row_cons;
            r_row_pres   <= n_row_pres;
            r_pair_total <= n_pair_total;
            r_pair_rows  <= n_pair_rows;
            r_set_total  <= n_set_total;
            r_set_pairs  <= n_set_pairs;
            r_out_valid  <= n_out_valid;
        end
    end

    // item fields, divider and output word: loaded before use
    always_ff @(posedge i_clk) begin
        r_diff       <= n_diff;
        r_k          <= n_k;
        r_klast      <= n_klast;
        r_row_ok     <= n_row_ok;
        r_row_close  <= n_row_close;
        r_pair_close <= n_pair_close;
        r_set_close  <= n_set_close;
        r_num        <= n_num;
        r_den        <= n_den;
        r_rem        <= n_rem;
        r_div_cnt    <= n_div_cnt;
        r_quot       <= n_quot;
        r_out_kind   <= n_out_kind;
        r_out_score  <= n_out_score;
        r_out_last   <= n_out_last;
    end

    // preserved comparisons never outnumber considered ones
    a_pres_le_cons: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_pres <= r_row_cons)
        else $error("row preserved count above considered count");

    // an accepted word keeps the block busy for at least the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> !o_in_ready)
        else $error("input taken again straight after a word");

    // the row counts are cleared by the time the pair close is looked at
    a_row_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lsa_pkg::ST_PAIR_CHECK) |-> (r_row_cons == '0 && r_row_pres == '0))
        else $error("row counts left over at pair check");

    // an overall word is always the last one of its item, and no score exceeds one
    a_set_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == lsa_pkg::KIND_SET) |-> r_out_last)
        else $error("overall score word not marked last");

    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_score <= lsa_pkg::ONE_Q16))
        else $error("score above one");

endmodule

`default_nettype wire

[test/lddt_score_accumulator_unit_tb.sv]
// self-checking testbench for lddt_score_accumulator_unit: column-pair words are scored
// by an in-bench predictor and the pair and overall score words are compared field by field
// depends on lsa_pkg and lddt_score_accumulator_unit
`timescale 1ns / 1ps

module lddt_score_accumulator_unit_tb;

    import lsa_pkg::*;

    // saturation limits of the running counters and totals, and the largest distance
    localparam int unsigned    CNT_MAX   = (1 << CNT_W) - 1;
    localparam int unsigned    ROWS_MAX  = (1 << ROWS_W) - 1;
    localparam int unsigned    PTOT_MAX  = (1 << PTOT_W) - 1;
    localparam int unsigned    PAIRS_MAX = (1 << PAIRS_W) - 1;
    localparam logic [31:0]    STOT_MAX  = 32'hFFFF_FFFF;
    localparam int unsigned    DIST_MAX  = (1 << DIST_W) - 1;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam int unsigned SETTLE_CYCLES = 160;    // row, pair and set divides back to back
    localparam int unsigned HOLD_CYCLES   = 400;    // long receiver hold-off
    localparam int unsigned LIMIT_NS      = 40_000_000;
    localparam int unsigned PRINT_CAP     = 30;

    // one column pair (i, j), packed in port order
    typedef struct packed {
        logic [DIST_W-1:0] dist_one;
        logic [DIST_W-1:0] dist_two;
        logic              row_core;
        logic              partner_core;
        logic              row_aligned;
        logic              partner_aligned;
        logic              same_column;
        logic              row_end;
        logic              pair_end;
        logic              set_end;
    } t_col_pair;

    typedef struct packed {
        logic               kind;
        logic [SCORE_W-1:0] score;
        logic               last;
    } t_score_word;

    // ---------------------------------------------------------------------------------
    // clock, reset and block ports
    // ---------------------------------------------------------------------------------
    logic                  i_clk             = 1'b0;
    logic                  i_rst_n           = 1'b0;
    logic                  i_cfg_valid       = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index       = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data        = '0;
    logic                  i_in_valid        = 1'b0;
    logic                  o_in_ready;
    logic [DIST_W-1:0]     i_dist_one        = '0;
    logic [DIST_W-1:0]     i_dist_two        = '0;
    logic                  i_row_core        = 1'b0;
    logic                  i_partner_core    = 1'b0;
    logic                  i_row_aligned     = 1'b0;
    logic                  i_partner_aligned = 1'b0;
    logic                  i_same_column     = 1'b0;
    logic                  i_row_end         = 1'b0;
    logic                  i_pair_end        = 1'b0;
    logic                  i_set_end         = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready       = 1'b0;
    logic                  o_kind;
    logic [SCORE_W-1:0]    o_score;
    logic                  o_last;

    always #2 i_clk = ~i_clk;

    lddt_score_accumulator_unit u_dut (.*);

    // ---------------------------------------------------------------------------------
    // bench state
    // ---------------------------------------------------------------------------------
    t_col_pair   column_pairs_q[$];     // words waiting to be offered
    t_score_word expected_scores[$];    // score words predicted, oldest first

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        hold_go       = 1'b0;
    int unsigned hold_left     = 0;

    int unsigned words_sent     = 0;
    int unsigned pair_words     = 0;
    int unsigned overall_words  = 0;
    int unsigned mismatches     = 0;
    int unsigned settings_used  = 1;

    // predictor copy of the registers, starting from their reset values
    logic                core_only_q = 1'b0;
    logic [DIST_W-1:0]   radius_q    = RADIUS_RST;
    logic [TCNT_W-1:0]   thr_count_q = THR_COUNT_RST;
    logic [DIST_W-1:0]   thr_q[THR_NUM] = '{THR_A_RST, THR_B_RST, THR_C_RST, THR_D_RST};

    // predictor copy of the running counters
    logic [CNT_W-1:0]    row_cons  = '0;
    logic [CNT_W-1:0]    row_pres  = '0;
    logic [PTOT_W-1:0]   pair_sum  = '0;
    logic [ROWS_W-1:0]   pair_rows = '0;
    logic [STOT_W-1:0]   set_sum   = '0;
    logic [PAIRS_W-1:0]  set_pairs = '0;

    // ---------------------------------------------------------------------------------
    // score prediction
    // ---------------------------------------------------------------------------------
    function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] lim);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, lim}) ? lim : s[31:0];
    endfunction

    // truncated q1.16 quotient, clamped at one, zero for an empty denominator
    function automatic logic [SCORE_W-1:0] q16_ratio(input logic [47:0] num,
                                                     input logic [31:0] den);
        logic [47:0] q;
        if (den == 0) return '0;
        q = num / den;
        return (q > ONE_Q16) ? ONE_Q16 : q[SCORE_W-1:0];
    endfunction

    task automatic score_column_pair(input t_col_pair w);
        logic               row_ok;
        logic [DIST_W-1:0]  diff;
        int unsigned        n_thr;
        logic [SCORE_W-1:0] part;
        t_score_word        res;
        row_ok = w.row_aligned && (!core_only_q || w.row_core);
        // every threshold in use is one comparison for a counted partner
        if (row_ok && !w.same_column && w.partner_aligned && (!core_only_q || w.partner_core)
            && w.dist_one <= radius_q) begin
            diff  = (w.dist_one >= w.dist_two) ? w.dist_one - w.dist_two
                                               : w.dist_two - w.dist_one;
            n_thr = (thr_count_q == 0) ? 1 : ((thr_count_q > THR_NUM) ? THR_NUM : thr_count_q);
            for (int k = 0; k < n_thr; k++) begin
                row_cons = sat_sum(row_cons, 1, CNT_MAX);
                if (diff <= thr_q[k]) row_pres = sat_sum(row_pres, 1, CNT_MAX);
            end
        end
        // the closing word's row flags decide whether the row is usable
        if (w.row_end || w.pair_end || w.set_end) begin
            if (row_ok) begin
                part      = q16_ratio({row_pres, 16'h0000}, row_cons);
                pair_sum  = sat_sum(pair_sum, part, PTOT_MAX);
                pair_rows = sat_sum(pair_rows, 1, ROWS_MAX);
            end
            row_cons = '0;
            row_pres = '0;
        end
        if (w.pair_end || w.set_end) begin
            part = q16_ratio(pair_sum, pair_rows);
            res  = '{kind: KIND_PAIR, score: part, last: !w.set_end};
            expected_scores.push_back(res);
            set_sum   = sat_sum(set_sum, part, STOT_MAX);
            set_pairs = sat_sum(set_pairs, 1, PAIRS_MAX);
            pair_sum  = '0;
            pair_rows = '0;
        end
        if (w.set_end) begin
            res = '{kind: KIND_SET, score: q16_ratio(set_sum, set_pairs), last: 1'b1};
            expected_scores.push_back(res);
            set_sum   = '0;
            set_pairs = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < PRINT_CAP)
            $display("%0t ns: score word %0d: %s is %0d, expected %0d",
                     $time, pair_words + overall_words, what, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------------------------
    // sender: offers the head of the queue, holds it until taken
    // ---------------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_words
        logic offer_next;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            offer_next = !i_in_valid;
            if (i_in_valid && o_in_ready) begin
                score_column_pair(column_pairs_q.pop_front());
                words_sent++;
                offer_next = 1'b1;
            end
            if (offer_next) begin
                if (column_pairs_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    {i_dist_one, i_dist_two, i_row_core, i_partner_core, i_row_aligned,
                     i_partner_aligned, i_same_column, i_row_end, i_pair_end,
                     i_set_end} <= column_pairs_q[0];
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here so the sender keeps offering meanwhile
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_go && hold_left == 0) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ---------------------------------------------------------------------------------
    // receiver: takes score words and checks them against the oldest prediction
    // ---------------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_scores
        t_score_word want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid === 1'b1 && i_out_ready) begin
                if (expected_scores.size() == 0) begin
                    report_mismatch("word with no score pending, score", o_score, 0);
                end else begin
                    want = expected_scores.pop_front();
                    if (o_kind !== want.kind)   report_mismatch("kind", o_kind, want.kind);
                    if (o_score !== want.score) report_mismatch("score", o_score, want.score);
                    if (o_last !== want.last)   report_mismatch("last", o_last, want.last);
                    if (want.kind == KIND_PAIR) pair_words++;
                    else                        overall_words++;
                end
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------------------
    // flags in port order: row_core, partner_core, row_aligned, partner_aligned,
    // same_column, row_end, pair_end, set_end
    function automatic t_col_pair col_pair(input logic [DIST_W-1:0] d1,
                                           input logic [DIST_W-1:0] d2,
                                           input logic [7:0] flags);
        return {d1, d2, flags};
    endfunction

    // one partner with distances near the radius and differences near the thresholds
    function automatic t_col_pair random_partner(input logic row_core, input logic row_aligned);
        t_col_pair   w;
        int          delta;
        int          d2;
        int unsigned pick;
        w    = '0;
        pick = $urandom_range(0, 7);
        if (pick < 5)       w.dist_one = $urandom_range(0, radius_q);
        else if (pick == 5) w.dist_one = radius_q;
        else                w.dist_one = $urandom_range(0, DIST_MAX);
        case ($urandom_range(0, 5))
            0: delta = 0;
            1: delta = thr_q[$urandom_range(0, THR_NUM - 1)];
            2: delta = thr_q[$urandom_range(0, THR_NUM - 1)] + 1;
            3: delta = int'(thr_q[$urandom_range(0, THR_NUM - 1)]) - 1;
            4: delta = $urandom_range(0, 2048);
            default: delta = $urandom_range(0, DIST_MAX);
        endcase
        if (delta < 0) delta = 0;
        if (delta > DIST_MAX) delta = DIST_MAX;
        d2 = $urandom_range(0, 1) ? w.dist_one + delta : w.dist_one - delta;
        if (d2 < 0 || d2 > DIST_MAX) d2 = w.dist_one + delta;
        if (d2 > DIST_MAX) d2 = w.dist_one - delta;
        if (d2 < 0) d2 = $urandom_range(0, DIST_MAX);
        w.dist_two        = d2;
        w.row_core        = row_core;
        w.row_aligned     = row_aligned;
        w.partner_core    = $urandom_range(0, 9) < 7;
        w.partner_aligned = $urandom_range(0, 9) != 0;
        w.same_column     = $urandom_range(0, 11) == 0;
        return w;
    endfunction

    // well-formed alignment: pairs of rows of partners, closing flags on the last words
    task automatic queue_alignment(input int unsigned n_pairs);
        t_col_pair   w;
        int unsigned n_rows, n_cols, p, r, c;
        logic        rc, ra;
        for (p = 0; p < n_pairs; p++) begin
            n_rows = $urandom_range(1, 4);
            for (r = 0; r < n_rows; r++) begin
                rc     = $urandom_range(0, 3) != 0;
                ra     = $urandom_range(0, 7) != 0;
                n_cols = $urandom_range(1, 6);
                for (c = 0; c < n_cols; c++) begin
                    w = random_partner(rc, ra);
                    if (c == n_cols - 1) begin
                        w.row_end = 1'b1;
                        // the closing word may carry other row flags than the row did
                        if ($urandom_range(0, 7) == 0) begin
                            w.row_core    = $urandom_range(0, 1);
                            w.row_aligned = $urandom_range(0, 1);
                        end
                        if (r == n_rows - 1) begin
                            w.pair_end = 1'b1;
                            w.set_end  = (p == n_pairs - 1);
                            if ($urandom_range(0, 4) == 0) w.row_end = 1'b0;
                            if (w.set_end && $urandom_range(0, 3) == 0) w.pair_end = 1'b0;
                        end
                    end
                    column_pairs_q.push_back(w);
                end
            end
        end
    endtask

    // broken sequences: closing flags scattered at random
    task automatic queue_noise(input int unsigned n);
        t_col_pair w;
        for (int unsigned k = 0; k < n; k++) begin
            w = random_partner($urandom_range(0, 1), $urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0) w.dist_one = $urandom_range(0, DIST_MAX);
            w.row_end  = $urandom_range(0, 3) == 0;
            w.pair_end = $urandom_range(0, 7) == 0;
            w.set_end  = $urandom_range(0, 15) == 0;
            column_pairs_q.push_back(w);
        end
    endtask

    task automatic queue_random(input int unsigned n_words);
        int unsigned start;
        start = column_pairs_q.size();
        while (column_pairs_q.size() - start < n_words) begin
            if ($urandom_range(0, 9) < 8) queue_alignment($urandom_range(1, 3));
            else                          queue_noise($urandom_range(1, 4));
        end
    endtask

    // register write; the predictor takes the value once the block has taken the word
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_CORE_ONLY:   core_only_q = val[0];
            CFG_RADIUS:      radius_q    = val;
            CFG_THR_COUNT:   thr_count_q = val[TCNT_W-1:0];
            CFG_THRESHOLD_A: thr_q[0]    = val;
            CFG_THRESHOLD_B: thr_q[1]    = val;
            CFG_THRESHOLD_C: thr_q[2]    = val;
            CFG_THRESHOLD_D: thr_q[3]    = val;
            default: ;
        endcase
    endtask

    // wait for every word to be taken and scored, then let row closes finish
    task automatic drain_block();
        do @(posedge i_clk);
        while (column_pairs_q.size() != 0 || i_in_valid || expected_scores.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        @(posedge i_clk);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // receiver stalls for a long stretch while the queue is full
    task automatic pulse_hold();
        @(posedge i_clk);
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
    endtask

    // ---------------------------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, sender idles in 16 percent of cycles, receiver in 75 percent
        set_idling(16, 75);
        // empty alignment closed at once
        column_pairs_q.push_back(col_pair(16'd0,     16'd0,     8'b0000_0001));
        // difference equal to the first threshold, then one above
        column_pairs_q.push_back(col_pair(16'd1000,  16'd1128,  8'b1111_0000));
        column_pairs_q.push_back(col_pair(16'd1000,  16'd1129,  8'b1111_0000));
        // partner exactly at the inclusion radius, then just beyond it
        column_pairs_q.push_back(col_pair(16'd3840,  16'd0,     8'b1111_0000));
        column_pairs_q.push_back(col_pair(16'd3841,  16'd3841,  8'b1111_0000));
        // widest difference, and a partner at the top of the distance range
        column_pairs_q.push_back(col_pair(16'd0,     16'hFFFF,  8'b1111_0000));
        column_pairs_q.push_back(col_pair(16'hFFFF,  16'hFFFF,  8'b1111_0000));
        // i equal to j adds nothing
        column_pairs_q.push_back(col_pair(16'd500,   16'd500,   8'b1111_1000));
        // partner with a gap closes the row
        column_pairs_q.push_back(col_pair(16'd500,   16'd500,   8'b1110_0100));
        // usable row with nothing considered scores zero
        column_pairs_q.push_back(col_pair(16'd500,   16'd500,   8'b1110_0100));
        // row with a gap is not counted
        column_pairs_q.push_back(col_pair(16'd500,   16'd500,   8'b1101_0100));
        // difference equal to the last threshold
        column_pairs_q.push_back(col_pair(16'd2000,  16'd3024,  8'b1111_0000));
        // pair end without row end still closes the row
        column_pairs_q.push_back(col_pair(16'd700,   16'd700,   8'b1111_0010));
        // pair with no usable row
        column_pairs_q.push_back(col_pair(16'd0,     16'd0,     8'b0000_0010));
        // set end alone closes row, pair and set
        column_pairs_q.push_back(col_pair(16'd100,   16'd100,   8'b1111_0001));
        // every flag high
        column_pairs_q.push_back(col_pair(16'hFFFF,  16'd0,     8'b1111_1111));
        // row and set end without pair end, non-core row
        column_pairs_q.push_back(col_pair(16'd1,     16'd0,     8'b0111_0101));
        column_pairs_q.push_back(col_pair(16'd200,   16'd72,    8'b1111_0110));
        column_pairs_q.push_back(col_pair(16'd0,     16'd0,     8'b1111_0111));
        queue_random(280);
        pulse_hold();
        drain_block();

        // core columns only, widest radius, one threshold at zero
        write_reg(CFG_CORE_ONLY, 16'hFFFF);
        write_reg(CFG_RADIUS, 16'hFFFF);
        write_reg(CFG_THR_COUNT, 16'd1);
        write_reg(CFG_THRESHOLD_A, 16'd0);
        write_reg(CFG_THRESHOLD_B, $urandom_range(0, DIST_MAX));
        settings_used++;
        queue_random(265);
        drain_block();

        // roles swapped: sender idles in 75 percent of cycles, receiver in 16 percent
        set_idling(75, 16);
        // zero radius, threshold count zero acting as one, widest thresholds
        write_reg(CFG_CORE_ONLY, 16'd0);
        write_reg(CFG_RADIUS, 16'd0);
        write_reg(CFG_THR_COUNT, 16'd0);
        write_reg(CFG_THRESHOLD_A, 16'hFFFF);
        write_reg(CFG_THRESHOLD_D, 16'hFFFF);
        settings_used++;
        queue_random(265);
        pulse_hold();
        drain_block();

        // threshold count above the number held saturates; a write to no register
        write_reg(CFG_THR_COUNT, 16'd7);
        write_reg(CFG_RADIUS, $urandom_range(1000, 5000));
        write_reg(CFG_CORE_ONLY, $urandom_range(0, 1));
        write_reg(CFG_THRESHOLD_A, $urandom_range(0, 1500));
        write_reg(CFG_THRESHOLD_B, $urandom_range(0, 1500));
        write_reg(CFG_THRESHOLD_C, $urandom_range(0, 1500));
        write_reg(CFG_THRESHOLD_D, $urandom_range(0, 1500));
        write_reg(CFG_UNUSED, $urandom_range(0, DIST_MAX));
        settings_used++;
        queue_random(265);
        drain_block();

        // neither side idles from here on
        set_idling(0, 0);
        write_reg(CFG_THR_COUNT, 16'd2);
        write_reg(CFG_CORE_ONLY, 16'd1);
        write_reg(CFG_RADIUS, 16'd3840);
        write_reg(CFG_THRESHOLD_A, $urandom_range(0, 2048));
        write_reg(CFG_THRESHOLD_B, $urandom_range(0, 2048));
        settings_used++;
        queue_random(265);
        drain_block();

        write_reg(CFG_THR_COUNT, 16'd5);
        write_reg(CFG_CORE_ONLY, 16'd0);
        write_reg(CFG_THRESHOLD_C, $urandom_range(0, 4096));
        write_reg(CFG_THRESHOLD_D, $urandom_range(0, DIST_MAX));
        settings_used++;
        queue_random(265);
        pulse_hold();
        drain_block();

        // two thresholds always pass, two only when the distances are equal
        write_reg(CFG_THR_COUNT, 16'd4);
        write_reg(CFG_RADIUS, 16'hFFFF);
        write_reg(CFG_THRESHOLD_A, 16'hFFFF);
        write_reg(CFG_THRESHOLD_B, 16'hFFFF);
        write_reg(CFG_THRESHOLD_C, 16'd0);
        write_reg(CFG_THRESHOLD_D, 16'd0);
        settings_used++;
        queue_random(265);
        drain_block();

        $display("covered %0d column-pair words under %0d register settings, with long stalls",
                 words_sent, settings_used);
        $display("checked %0d pair scores and %0d overall scores, %0d mismatches",
                 pair_words, overall_words, mismatches);
        if (mismatches == 0) begin
            $display("[lddt_score_accumulator_unit] OK");
        end else begin
            $display("[lddt_score_accumulator_unit] ERROR");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(LIMIT_NS);
        $display("timeout with %0d score words still expected", expected_scores.size());
        $display("[lddt_score_accumulator_unit] ERROR");
        $finish;
    end

endmodule

[sim.f]
sv/lsa_pkg.sv
sv/lddt_score_accumulator_unit.sv
test/lddt_score_accumulator_unit_tb.sv
